[hdl/hhfp_pkg.sv]
// Shared types, codes and helpers for the HTTP header field parser.
`timescale 1ns / 1ps

package hhfp_pkg;

    localparam int NAME_LEN_W  = 10;
    localparam int VALUE_LEN_W = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [NAME_LEN_W-1:0]  MAX_NAME_RESET  = 10'd256;
    localparam logic [VALUE_LEN_W-1:0] MAX_VALUE_RESET = 16'd8192;

    // Configuration register indexes
    localparam logic REG_MAX_NAME  = 1'b0;
    localparam logic REG_MAX_VALUE = 1'b1;

    // Commands
    localparam logic [1:0] CMD_DATA    = 2'd0;
    localparam logic [1:0] CMD_END     = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_NAME       = 3'd0;
    localparam logic [2:0] KIND_VALUE      = 3'd1;
    localparam logic [2:0] KIND_COMPLETE   = 3'd2;
    localparam logic [2:0] KIND_DONE       = 3'd3;
    localparam logic [2:0] KIND_INCOMPLETE = 3'd4;
    localparam logic [2:0] KIND_ERROR      = 3'd5;

    // Error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NO_COLON   = 3'd1;
    localparam logic [2:0] ERR_EMPTY      = 3'd2;
    localparam logic [2:0] ERR_NAME_LONG  = 3'd3;
    localparam logic [2:0] ERR_VALUE_LONG = 3'd4;
    localparam logic [2:0] ERR_BAD_CHAR   = 3'd5;

    // Characters
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SP    = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] NAME_LOW   = 8'd32;
    localparam logic [7:0] NAME_HIGH  = 8'd127;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic [2:0] code;
    } result_t;

    // Up to two results caused by one request
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } result_pair_t;

    function automatic result_pair_t push_result(result_pair_t p, logic [2:0] kind,
                                                 logic [7:0] data, logic [2:0] code);
        result_pair_t q;
        result_t      r;
        q      = p;
        r.kind = kind;
        r.data = data;
        r.code = code;
        if (p.cnt == 2'd0) begin
            q.r0  = r;
            q.cnt = 2'd1;
        end else if (p.cnt == 2'd1) begin
            q.r1  = r;
            q.cnt = 2'd2;
        end
        return q;
    endfunction

endpackage

[hdl/hhfp_front.sv]
// Front end: accepts requests, runs the header parser state and builds result pairs.
`timescale 1ns / 1ps

module hhfp_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [1:0]                          cmd,
    input  logic [7:0]                          data_byte,
    input  logic [hhfp_pkg::NAME_LEN_W-1:0]     max_name,
    input  logic [hhfp_pkg::VALUE_LEN_W-1:0]    max_value,
    output hhfp_pkg::result_pair_t              pair
);

    typedef enum logic [2:0] {
        PH_NAME,
        PH_LEAD,
        PH_VALUE,
        PH_AFTER,
        PH_IDLE
    } phase_t;

    phase_t                              phase_reg, phase_next;
    logic [hhfp_pkg::NAME_LEN_W-1:0]     name_count_reg, name_count_next;
    logic [hhfp_pkg::VALUE_LEN_W-1:0]    value_count_reg, value_count_next;
    logic                                held_reg, held_next;

    always_comb
    begin
        hhfp_pkg::result_pair_t p;
        logic       do_name;
        logic       do_char;
        logic [7:0] ch;
        logic       cont;
        logic       is_blank;

        p                = '0;
        phase_next       = phase_reg;
        name_count_next  = name_count_reg;
        value_count_next = value_count_reg;
        held_next        = held_reg;
        do_name          = 1'b0;
        do_char          = 1'b0;
        ch               = data_byte;
        cont             = 1'b1;
        is_blank         = (data_byte == hhfp_pkg::CHAR_SP) ||
                           (data_byte == hhfp_pkg::CHAR_TAB);

        case (cmd)
            hhfp_pkg::CMD_DATA:
            begin
                case (phase_reg)
                    PH_NAME:
                    begin
                        do_name = 1'b1;
                    end
                    PH_LEAD, PH_VALUE:
                    begin
                        if (held_next) begin
                            held_next = 1'b0;
                            if (data_byte == hhfp_pkg::CHAR_LF) begin
                                cont = 1'b0;
                                if (phase_next == PH_LEAD && value_count_next == '0) begin
                                    p = hhfp_pkg::push_result(p, hhfp_pkg::KIND_ERROR, 8'd0,
                                                              hhfp_pkg::ERR_EMPTY);
                                    phase_next = PH_IDLE;
                                end else begin
                                    phase_next = PH_AFTER;
                                end
                            end else begin
                                phase_next = PH_VALUE;
                                if (value_count_next >= max_value) begin
                                    p = hhfp_pkg::push_result(p, hhfp_pkg::KIND_ERROR, 8'd0,
                                                              hhfp_pkg::ERR_VALUE_LONG);
                                    phase_next = PH_IDLE;
                                    cont       = 1'b0;
                                end else begin
                                    value_count_next = value_count_next + 1'b1;
                                    p = hhfp_pkg::push_result(p, hhfp_pkg::KIND_VALUE,
                                                              hhfp_pkg::CHAR_CR,
                                                              hhfp_pkg::ERR_NONE);
                                end
                            end
                        end
                        if (cont) begin
                            if (data_byte == hhfp_pkg::CHAR_CR) begin
                                held_next = 1'b1;
                            end else if (data_byte == hhfp_pkg::CHAR_LF) begin
                                if (phase_next == PH_LEAD && value_count_next == '0) begin
                                    p = hhfp_pkg::push_result(p, hhfp_pkg::KIND_ERROR, 8'd0,
                                                              hhfp_pkg::ERR_EMPTY);
                                    phase_next = PH_IDLE;
                                end else begin
                                    phase_next = PH_AFTER;
                                end
                            end else if (phase_next == PH_LEAD && is_blank) begin
                                // trim leading blank
                            end else begin
                                phase_next = PH_VALUE;
                                if (value_count_next >= max_value) begin
                                    p = hhfp_pkg::push_result(p, hhfp_pkg::KIND_ERROR, 8'd0,
                                                              hhfp_pkg::ERR_VALUE_LONG);
                                    phase_next = PH_IDLE;
                                end else begin
                                    value_count_next = value_count_next + 1'b1;
                                    p = hhfp_pkg::push_result(p, hhfp_pkg::KIND_VALUE,
                                                              data_byte, hhfp_pkg::ERR_NONE);
                                end
                            end
                        end
                    end
                    PH_AFTER:
                    begin
                        if (is_blank) begin
                            // fold: join with one space
                            if (value_count_next >= max_value) begin
                                p = hhfp_pkg::push_result(p, hhfp_pkg::KIND_ERROR, 8'd0,
                                                          hhfp_pkg::ERR_VALUE_LONG);
                                phase_next = PH_IDLE;
                            end else begin
                                value_count_next = value_count_next + 1'b1;
                                p = hhfp_pkg::push_result(p, hhfp_pkg::KIND_VALUE,
                                                          hhfp_pkg::CHAR_SP,
                                                          hhfp_pkg::ERR_NONE);
                                phase_next = PH_LEAD;
                            end
                        end else begin
                            p = hhfp_pkg::push_result(p, hhfp_pkg::KIND_COMPLETE, 8'd0,
                                                      hhfp_pkg::ERR_NONE);
                            phase_next       = PH_NAME;
                            name_count_next  = '0;
                            value_count_next = '0;
                            held_next        = 1'b0;
                            do_name          = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                if (do_name) begin
                    if (held_next) begin
                        held_next = 1'b0;
                        if (data_byte == hhfp_pkg::CHAR_LF) begin
                            p = hhfp_pkg::push_result(p, hhfp_pkg::KIND_DONE, 8'd0,
                                                      hhfp_pkg::ERR_NONE);
                            phase_next = PH_IDLE;
                        end else begin
                            do_char = 1'b1;
                            ch      = hhfp_pkg::CHAR_CR;
                        end
                    end else if (data_byte == hhfp_pkg::CHAR_COLON) begin
                        if (name_count_next == '0) begin
                            p = hhfp_pkg::push_result(p, hhfp_pkg::KIND_ERROR, 8'd0,
                                                      hhfp_pkg::ERR_EMPTY);
                            phase_next = PH_IDLE;
                        end else begin
                            phase_next       = PH_LEAD;
                            value_count_next = '0;
                        end
                    end else if (data_byte == hhfp_pkg::CHAR_LF) begin
                        if (name_count_next == '0) begin
                            p = hhfp_pkg::push_result(p, hhfp_pkg::KIND_DONE, 8'd0,
                                                      hhfp_pkg::ERR_NONE);
                        end else begin
                            p = hhfp_pkg::push_result(p, hhfp_pkg::KIND_ERROR, 8'd0,
                                                      hhfp_pkg::ERR_NO_COLON);
                        end
                        phase_next = PH_IDLE;
                    end else if (data_byte == hhfp_pkg::CHAR_CR && name_count_next == '0) begin
                        held_next = 1'b1;
                    end else begin
                        do_char = 1'b1;
                    end
                end

                if (do_char) begin
                    if (name_count_next >= max_name) begin
                        p = hhfp_pkg::push_result(p, hhfp_pkg::KIND_ERROR, 8'd0,
                                                  hhfp_pkg::ERR_NAME_LONG);
                        phase_next = PH_IDLE;
                    end else if (ch <= hhfp_pkg::NAME_LOW || ch >= hhfp_pkg::NAME_HIGH) begin
                        p = hhfp_pkg::push_result(p, hhfp_pkg::KIND_ERROR, 8'd0,
                                                  hhfp_pkg::ERR_BAD_CHAR);
                        phase_next = PH_IDLE;
                    end else begin
                        name_count_next = name_count_next + 1'b1;
                        p = hhfp_pkg::push_result(p, hhfp_pkg::KIND_NAME, ch,
                                                  hhfp_pkg::ERR_NONE);
                    end
                end

                // every error drops a held return
                if (phase_next == PH_IDLE) begin
                    held_next = 1'b0;
                end
            end
            hhfp_pkg::CMD_END:
            begin
                if (phase_reg != PH_IDLE) begin
                    if (phase_reg == PH_AFTER ||
                        ((phase_reg == PH_LEAD || phase_reg == PH_VALUE) &&
                         value_count_reg != '0)) begin
                        p = hhfp_pkg::push_result(p, hhfp_pkg::KIND_COMPLETE, 8'd0,
                                                  hhfp_pkg::ERR_NONE);
                    end
                    p = hhfp_pkg::push_result(p, hhfp_pkg::KIND_INCOMPLETE, 8'd0,
                                              hhfp_pkg::ERR_NONE);
                    phase_next = PH_IDLE;
                    held_next  = 1'b0;
                end
            end
            hhfp_pkg::CMD_RESTART:
            begin
                phase_next       = PH_NAME;
                name_count_next  = '0;
                value_count_next = '0;
                held_next        = 1'b0;
            end
            default:
            begin
            end
        endcase

        pair = p;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg       <= PH_NAME;
            name_count_reg  <= '0;
            value_count_reg <= '0;
            held_reg        <= 1'b0;
        end else if (accept) begin
            phase_reg       <= phase_next;
            name_count_reg  <= name_count_next;
            value_count_reg <= value_count_next;
            held_reg        <= held_next;
        end
    end

endmodule

[hdl/hhfp_queue.sv]
// Short queue of result pairs between the parser front end and the output back end.
`timescale 1ns / 1ps

module hhfp_queue #(
    parameter int DEPTH = hhfp_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  hhfp_pkg::result_pair_t push_data,
    output logic                   full,
    input  logic                   pop,
    output logic                   empty,
    output hhfp_pkg::result_pair_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    hhfp_pkg::result_pair_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hdl/hhfp_back.sv]
// Back end: holds one result pair and hands its results out one per cycle while out_stall is low.
`timescale 1ns / 1ps

module hhfp_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  hhfp_pkg::result_pair_t q_data,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             kind,
    output logic [7:0]             out_byte,
    output logic [2:0]             error_code,
    output logic                   last
);

    hhfp_pkg::result_pair_t hold_reg;
    logic                   valid_reg;
    logic                   idx_reg;
    logic                   on_last;
    logic                   taken;
    hhfp_pkg::result_t      cur;

    assign on_last = idx_reg ? 1'b1 : (hold_reg.cnt == 2'd1);
    assign taken   = valid_reg && !out_stall;
    assign q_pop   = !q_empty && (!valid_reg || (taken && on_last));

    assign cur        = idx_reg ? hold_reg.r1 : hold_reg.r0;
    assign out_valid  = valid_reg;
    assign kind       = cur.kind;
    assign out_byte   = cur.data;
    assign error_code = cur.code;
    assign last       = on_last;

    always_ff @(posedge clk)
    begin
        if (q_pop) begin
            hold_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end else begin
            if (q_pop) begin
                valid_reg <= 1'b1;
                idx_reg   <= 1'b0;
            end else if (taken) begin
                if (on_last) begin
                    valid_reg <= 1'b0;
                    idx_reg   <= 1'b0;
                end else begin
                    idx_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[hdl/http_header_field_parser_top.sv]
// Top level of the HTTP/1.1 header field parser: config registers, front, queue, back.
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// -------   ---------------------   -----------------------------------------
// in        in_valid / in_stall     cmd, data_byte
// out       out_valid / out_stall   kind, out_byte, error_code, last
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// The front end stalls only when the result queue is full, else it parses one
// request per cycle. Its zero to two results pass the result queue and the
// back end's hold register to the output, one per cycle unless the output
// stalls. Throughput is one request per cycle while each yields at most one
// result; one with two results holds the output stage until both are taken.
// Reset clears parser state, queue and output stage, loads length defaults.

module http_header_field_parser_top #(
    parameter int QUEUE_DEPTH = hhfp_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       cmd,
    input  logic [7:0]                       data_byte,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [2:0]                       kind,
    output logic [7:0]                       out_byte,
    output logic [2:0]                       error_code,
    output logic                             last,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_index,
    input  logic [hhfp_pkg::VALUE_LEN_W-1:0] cfg_data
);

    logic [hhfp_pkg::NAME_LEN_W-1:0]  max_name_reg;
    logic [hhfp_pkg::VALUE_LEN_W-1:0] max_value_reg;

    logic                   accept;
    logic                   q_full, q_empty, q_pop;
    hhfp_pkg::result_pair_t pair, q_data;

    // Config writes are always taken; software writes only while idle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_name_reg  <= hhfp_pkg::MAX_NAME_RESET;
            max_value_reg <= hhfp_pkg::MAX_VALUE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                hhfp_pkg::REG_MAX_NAME:  max_name_reg  <= cfg_data[hhfp_pkg::NAME_LEN_W-1:0];
                hhfp_pkg::REG_MAX_VALUE: max_value_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Hold off new requests only when there is no room for their results.
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    hhfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (cmd),
        .data_byte (data_byte),
        .max_name  (max_name_reg),
        .max_value (max_value_reg),
        .pair      (pair)
    );

    // Drop requests that produce no result; queue the rest.
    hhfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && (pair.cnt != 2'd0)),
        .push_data (pair),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_data)
    );

    hhfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .out_byte   (out_byte),
        .error_code (error_code),
        .last       (last)
    );

endmodule

[test/hhfp_event_tracker.sv]
// Scoreboard package: header parse predictor and queue of expected parser results.
`timescale 1ns / 1ps

package hhfp_check_pkg;

    import hhfp_pkg::*;

    // Code 3 on the command field carries no meaning and must be dropped.
    localparam logic [1:0] CMD_IGNORED = 2'd3;

    typedef enum logic [2:0] {AT_NAME, AT_LEAD, AT_VALUE, AT_AFTER, AT_IDLE} parse_phase_e;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic [2:0] code;
        logic       last;
    } header_event_t;

    class header_event_tracker;
        logic [NAME_LEN_W-1:0]  name_limit;
        logic [VALUE_LEN_W-1:0] value_limit;
        parse_phase_e           phase;
        int unsigned            name_count;
        int unsigned            value_count;
        bit                     held_cr;
        header_event_t          step_events[$];
        header_event_t          awaited[$];
        int unsigned            mismatches;
        int unsigned            checked;
        int unsigned            requests;

        function new();
            name_limit  = MAX_NAME_RESET;
            value_limit = MAX_VALUE_RESET;
            mismatches  = 0;
            checked     = 0;
            requests    = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase       = AT_NAME;
            name_count  = 0;
            value_count = 0;
            held_cr     = 1'b0;
        endfunction

        function void write_register(logic index, logic [VALUE_LEN_W-1:0] data);
            if (index == REG_MAX_NAME)
                name_limit = data[NAME_LEN_W-1:0];
            else
                value_limit = data;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void add_event(logic [2:0] kind, logic [7:0] data, logic [2:0] code);
            header_event_t ev;
            ev.kind = kind;
            ev.data = data;
            ev.code = code;
            ev.last = 1'b0;
            if (step_events.size() < 2)
                step_events.push_back(ev);
        endfunction

        function void fail(logic [2:0] code);
            add_event(KIND_ERROR, 8'h00, code);
            phase   = AT_IDLE;
            held_cr = 1'b0;
        endfunction

        function bit emit_value(logic [7:0] b);
            if (value_count >= value_limit) begin
                fail(ERR_VALUE_LONG);
                return 1'b0;
            end
            value_count++;
            add_event(KIND_VALUE, b, ERR_NONE);
            return 1'b1;
        endfunction

        function void name_char(logic [7:0] b);
            if (name_count >= name_limit)
                fail(ERR_NAME_LONG);
            else if (b <= NAME_LOW || b >= NAME_HIGH)
                fail(ERR_BAD_CHAR);
            else begin
                name_count++;
                add_event(KIND_NAME, b, ERR_NONE);
            end
        endfunction

        function void name_byte(logic [7:0] b);
            if (held_cr) begin
                held_cr = 1'b0;
                if (b == CHAR_LF) begin
                    add_event(KIND_DONE, 8'h00, ERR_NONE);
                    phase = AT_IDLE;
                end else begin
                    name_char(CHAR_CR);
                end
                return;
            end
            if (b == CHAR_COLON) begin
                if (name_count == 0)
                    fail(ERR_EMPTY);
                else begin
                    phase       = AT_LEAD;
                    value_count = 0;
                end
            end else if (b == CHAR_LF) begin
                if (name_count == 0) begin
                    add_event(KIND_DONE, 8'h00, ERR_NONE);
                    phase = AT_IDLE;
                end else begin
                    fail(ERR_NO_COLON);
                end
            end else if (b == CHAR_CR && name_count == 0) begin
                held_cr = 1'b1;
            end else begin
                name_char(b);
            end
        endfunction

        function void end_of_line();
            if (phase == AT_LEAD && value_count == 0)
                fail(ERR_EMPTY);
            else
                phase = AT_AFTER;
        endfunction

        function void value_byte(logic [7:0] b);
            if (held_cr) begin
                held_cr = 1'b0;
                if (b == CHAR_LF) begin
                    end_of_line();
                    return;
                end
                phase = AT_VALUE;
                if (!emit_value(CHAR_CR))
                    return;
            end
            if (b == CHAR_CR)
                held_cr = 1'b1;
            else if (b == CHAR_LF)
                end_of_line();
            else if (!(phase == AT_LEAD && (b == CHAR_SP || b == CHAR_TAB))) begin
                // blanks ahead of the value are trimmed, everything else is value
                phase = AT_VALUE;
                void'(emit_value(b));
            end
        endfunction

        function void data_step(logic [7:0] b);
            case (phase)
                AT_NAME:           name_byte(b);
                AT_LEAD, AT_VALUE: value_byte(b);
                AT_AFTER: begin
                    if (b == CHAR_SP || b == CHAR_TAB) begin
                        if (emit_value(CHAR_SP))
                            phase = AT_LEAD;
                    end else begin
                        add_event(KIND_COMPLETE, 8'h00, ERR_NONE);
                        clear_state();
                        name_byte(b);
                    end
                end
                default: ;
            endcase
        endfunction

        function void end_step();
            if (phase == AT_IDLE)
                return;
            if (phase == AT_AFTER ||
                ((phase == AT_LEAD || phase == AT_VALUE) && value_count > 0))
                add_event(KIND_COMPLETE, 8'h00, ERR_NONE);
            add_event(KIND_INCOMPLETE, 8'h00, ERR_NONE);
            phase   = AT_IDLE;
            held_cr = 1'b0;
        endfunction

        function void note_request(logic [1:0] cmd, logic [7:0] b);
            header_event_t ev;
            step_events.delete();
            requests++;
            case (cmd)
                CMD_DATA:    data_step(b);
                CMD_END:     end_step();
                CMD_RESTART: clear_state();
                default: ;
            endcase
            if (step_events.size() > 0)
                step_events[step_events.size() - 1].last = 1'b1;
            foreach (step_events[i]) begin
                ev = step_events[i];
                awaited.push_back(ev);
            end
        endfunction

        function void compare_field(string label, int want, int got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, label, want, got);
            end
        endfunction

        function void check_result(logic [2:0] kind, logic [7:0] data, logic [2:0] code,
                                   logic last);
            header_event_t want;
            checked++;
            if (awaited.size() == 0) begin
                mismatches++;
                $display("%0t: result with none expected: kind %0d byte %0d code %0d last %0d",
                         $time, kind, data, code, last);
                return;
            end
            want = awaited.pop_front();
            compare_field("kind", want.kind, kind);
            compare_field("out_byte", want.data, data);
            compare_field("error_code", want.code, code);
            compare_field("last", want.last, last);
        endfunction
    endclass

endpackage

[test/testbench.sv]
// Top-level testbench for the HTTP header field parser: stimulus, handshakes and checking.
`timescale 1ns / 1ps

module testbench;

    import hhfp_pkg::*;
    import hhfp_check_pkg::*;

    // Bound on the whole run; the slowest legal run stays far below it.
    localparam int CYCLE_LIMIT = 200000;
    // Length of the output hold-off used to back the parser up.
    localparam int HOLD_CYCLES = 120;
    // Quiet cycles after the last expected result: pipeline plus result queue.
    localparam int SETTLE_CYCLES = 10;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic [1:0]             cmd       = CMD_DATA;
    logic [7:0]             data_byte = 8'h00;
    logic                   out_stall = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_index = REG_MAX_NAME;
    logic [VALUE_LEN_W-1:0] cfg_data  = '0;

    logic                   in_stall;
    logic                   out_valid;
    logic [2:0]             kind;
    logic [7:0]             out_byte;
    logic [2:0]             error_code;
    logic                   last;
    logic                   cfg_ready;

    // Idle and stall rates in percent, changed between phases only.
    int unsigned            send_idle_pct = 0;
    int unsigned            stall_pct     = 0;
    logic                   hold_off      = 1'b0;
    int unsigned            sent_count    = 0;
    int unsigned            cycle_count   = 0;

    header_event_tracker    tracker;

    http_header_field_parser_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .out_byte   (out_byte),
        .error_code (error_code),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // Receiver side: stall at random, or hold for the whole hold-off stretch.
    always @(posedge clk)
    begin
        out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    // Check every result that is taken at this edge against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(kind, out_byte, error_code, last);
    end

    // Watchdog: end the run if it never drains.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results still expected",
                 cycle_count, tracker.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offer one request, idling first at the current rate, and hold it until taken.
    task automatic send_request(input logic [1:0] c, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_request(c, b);
        sent_count++;
    endtask

    task automatic send_data(input logic [7:0] b);
        send_request(CMD_DATA, b);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_data(s[i]);
    endtask

    // Drop the valid and wait until every expected result has been taken.
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both length registers back to back, valid held high across the pair.
    // Junk in the upper bits of the name write must be ignored by the block.
    task automatic configure(input logic [NAME_LEN_W-1:0] name_lim,
                             input logic [VALUE_LEN_W-1:0] value_lim);
        logic [VALUE_LEN_W-1:0] name_word;
        name_word = {6'($urandom_range(63)), name_lim};
        cfg_valid <= 1'b1;
        cfg_index <= REG_MAX_NAME;
        cfg_data  <= name_word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.write_register(REG_MAX_NAME, name_word);
        cfg_index <= REG_MAX_VALUE;
        cfg_data  <= value_lim;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.write_register(REG_MAX_VALUE, value_lim);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_blank();
        return ($urandom_range(1) == 0) ? CHAR_SP : CHAR_TAB;
    endfunction

    // Value bytes: anything but a line feed, with plenty of carriage returns.
    function automatic logic [7:0] pick_value_byte();
        logic [7:0] ch;
        ch = 8'($urandom_range(255));
        if ($urandom_range(9) == 0)
            ch = CHAR_CR;
        else if (ch == CHAR_LF)
            ch = CHAR_SP;
        return ch;
    endfunction

    // Occasionally slip in a fully random request: any command, any byte.
    task automatic maybe_noise();
        if ($urandom_range(99) < 3)
            send_request(2'($urandom_range(3)), 8'($urandom_range(255)));
    endtask

    task automatic send_line_end();
        if ($urandom_range(1) == 0)
            send_data(CHAR_CR);
        send_data(CHAR_LF);
    endtask

    task automatic send_value(input int unsigned len);
        int unsigned k;
        for (k = 0; k < len; k++)
        begin
            send_data(pick_value_byte());
            maybe_noise();
        end
    endtask

    // One header section: restart, a few headers with blanks, folds and odd
    // bytes, then a blank line or an early end of input. Lengths run past
    // the small register settings so that the too-long errors show up.
    task automatic send_message();
        int unsigned n_headers;
        int unsigned h;
        int unsigned k;
        logic [7:0]  ch;
        n_headers = $urandom_range(0, 4);
        send_request(CMD_RESTART, 8'($urandom_range(255)));
        for (h = 0; h < n_headers; h++)
        begin
            for (k = $urandom_range(1, 7); k > 0; k--)
            begin
                do
                    ch = 8'($urandom_range(33, 126));
                while (ch == CHAR_COLON);
                send_data(ch);
                maybe_noise();
            end
            // now and then break the line before the colon
            if ($urandom_range(11) == 0)
                send_data(CHAR_LF);
            send_data(CHAR_COLON);
            repeat ($urandom_range(0, 2)) send_data(pick_blank());
            send_value($urandom_range(0, 9));
            send_line_end();
            if ($urandom_range(3) == 0)
            begin
                // folded continuation line
                repeat ($urandom_range(1, 2)) send_data(pick_blank());
                send_value($urandom_range(0, 5));
                send_line_end();
            end
        end
        case ($urandom_range(5))
            0:       send_request(CMD_END, 8'($urandom_range(255)));
            1:       send_data(CHAR_LF);
            default: send_line_end();
        endcase
        maybe_noise();
    endtask

    task automatic run_random(input int unsigned n_items);
        int unsigned stop_at;
        stop_at = sent_count + n_items;
        while (sent_count < stop_at)
            send_message();
    endtask

    task automatic run_phase(input logic [NAME_LEN_W-1:0] name_lim,
                             input logic [VALUE_LEN_W-1:0] value_lim,
                             input int unsigned idle, input int unsigned stall,
                             input int unsigned n_items);
        drain();
        configure(name_lim, value_lim);
        send_idle_pct = idle;
        stall_pct     = stall;
        run_random(n_items);
    endtask

    initial
    begin
        tracker = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset lengths, no idling.
        // Trimmed blanks, an all-ones value byte, a held return that turns
        // into a value byte, an ignored command code, then a fold.
        send_text("A:");
        send_data(CHAR_SP);
        send_data(CHAR_TAB);
        send_data(8'hFF);
        send_data(CHAR_CR);
        send_data("y");
        send_request(CMD_IGNORED, 8'h5A);
        send_data(CHAR_CR);
        send_data(CHAR_LF);
        send_data(CHAR_TAB);
        send_data("z");
        send_data(CHAR_LF);
        // header complete and the next name byte from one request
        send_data("B");
        // line feed inside a name: no colon
        send_data(CHAR_LF);
        // colon with nothing before it
        send_request(CMD_RESTART, 8'h00);
        send_data(CHAR_COLON);
        // line feed before any value byte
        send_request(CMD_RESTART, 8'hFF);
        send_text("D:");
        send_data(CHAR_LF);
        // held return at line start followed by another byte: bad name character
        send_request(CMD_RESTART, 8'h00);
        send_data(CHAR_CR);
        send_data(8'h00);
        // end of input with a header pending: complete, then incomplete
        send_request(CMD_RESTART, 8'h00);
        send_text("G:v");
        send_request(CMD_END, 8'hFF);
        // blank line ends the section; a later end of input is dropped
        send_request(CMD_RESTART, 8'h00);
        send_data(CHAR_CR);
        send_data(CHAR_LF);
        send_request(CMD_END, 8'h00);

        // Zero lengths: every name byte, then every value byte, is too long.
        drain();
        configure(10'd0, 16'd0);
        send_request(CMD_RESTART, 8'h00);
        send_data("A");
        drain();
        configure(10'd1, 16'd0);
        send_request(CMD_RESTART, 8'h00);
        send_text("A:b");

        // Random part across settings and idling patterns.
        run_phase(10'd1023, 16'd65535, 0, 0, 60);
        run_phase(10'd4, 16'd6, 61, 0, 60);
        run_phase(10'd1, 16'd1, 0, 61, 50);
        run_phase(10'd9, 16'd12, 19, 19, 70);

        // Back-pressure: hold the output for a long stretch while requests
        // keep coming, so the result queue fills and the input stalls.
        drain();
        configure(MAX_NAME_RESET, MAX_VALUE_RESET);
        send_idle_pct = 0;
        stall_pct     = 0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off <= 1'b0;
            end
            run_random(40);
        join

        drain();
        $display("Sent %0d requests and checked %0d results over seven length settings,",
                 tracker.requests, tracker.checked);
        $display("with sender gaps, receiver stalls and one long output hold-off.");
        if (tracker.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
